// ===== rtl/sb2d_pkg.sv =====
// ----------------------------------------------------------------------------
// sb2d_pkg: shared constants for the signed binary to decimal text converter
// Holds the character width and the ASCII codes that the converter emits.
// ----------------------------------------------------------------------------
package sb2d_pkg;

   // Width of one emitted character code.
   localparam int CHAR_WIDTH = 6;

   // Width of one packed BCD digit.
   localparam int DIGIT_WIDTH = 4;

   // ASCII codes, cut to the character width.
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

   // Threshold and correction of the shift-and-add-three step.
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJ_MIN = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJ_ADD = 4'd3;

   typedef logic [DIGIT_WIDTH-1:0] digit_type;

endpackage

// ===== rtl/signed_binary_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core: signed integer to decimal ASCII text
// Converts one two's-complement word into its decimal characters, sign first,
// one character per output word, with the last character flagged.
// ----------------------------------------------------------------------------
// Steps: the word is taken, its magnitude goes through bit-serial double dabble
// one bit at a time, leading zeros are dropped one digit at a time, then the
// sign (if negative) and the digits are emitted one character at a time. The
// next word is taken while the last character of the previous word still waits;
// output stalls hold the emission of the sign and the digits.
// Reset is synchronous and returns the controller to idle with no output.
module signed_binary_to_decimal_ascii_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [DATA_WIDTH-1:0]          req_value,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sb2d_pkg::CHAR_WIDTH-1:0]       rsp_character,
   output logic                                  rsp_last
);

   import sb2d_pkg::*;

   // Decimal digits needed for a magnitude of DATA_WIDTH bits.
   localparam int NUM_DIGITS = (DATA_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_WIDTH  = NUM_DIGITS * DIGIT_WIDTH;
   localparam int BIT_CNT_W  = $clog2(DATA_WIDTH + 1);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic [DATA_WIDTH-1:0]    mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [BCD_WIDTH-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]     dig_cnt_ff, dig_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]    rsp_character_ff, rsp_character_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [DATA_WIDTH-1:0]    value_u;
   logic [DATA_WIDTH-1:0]    value_neg;
   logic [BCD_WIDTH-1:0]     bcd_adj;
   digit_type                top_digit;
   logic                     out_free;

   // Magnitude of a negative input; the most negative value maps onto itself,
   // which read as unsigned is its exact magnitude.
   assign value_u   = req_value;
   assign value_neg = ~value_u + DATA_WIDTH'(1);

   // Add three to every digit of five or more before the next shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] >= DIGIT_ADJ_MIN) begin
            bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
               bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] + DIGIT_ADJ_ADD;
         end else begin
            bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] = bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_WIDTH-1 -: DIGIT_WIDTH];

   // The output register can take a new word when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Controller: convert, drop leading zeros, then emit the sign if negative and the digits.
   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      bcd_in           = bcd_ff;
      bit_cnt_in       = bit_cnt_ff;
      dig_cnt_in       = dig_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in     = value_u[DATA_WIDTH-1];
               mag_in     = value_u[DATA_WIDTH-1] ? value_neg : value_u;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(DATA_WIDTH);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            // Shift one magnitude bit into the BCD register.
            bcd_in     = {bcd_adj[BCD_WIDTH-2:0], mag_ff[DATA_WIDTH-1]};
            mag_in     = {mag_ff[DATA_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               dig_cnt_in = DIG_CNT_W'(NUM_DIGITS);
               state_in   = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Drop leading zeros, but always keep the units digit.
            if (top_digit == '0 && dig_cnt_ff != DIG_CNT_W'(1)) begin
               bcd_in     = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_ZERO + CHAR_WIDTH'(top_digit);
               rsp_last_in      = (dig_cnt_ff == DIG_CNT_W'(1));
               bcd_in     = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
               if (dig_cnt_ff == DIG_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      bcd_ff           <= bcd_in;
      bit_cnt_ff       <= bit_cnt_in;
      dig_cnt_ff       <= dig_cnt_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // An accepted word always starts a conversion.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONV))
      else $error("accepted word did not start a conversion");

   // Every emitted character is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_MINUS ||
                     (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_ZERO + 6'd9)))
      else $error("emitted character is not a sign or a digit");

   // The sign is never the final character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_character == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign flagged as last character");

   // The units digit carries the last flag.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && dig_cnt_ff == DIG_CNT_W'(1)) |=>
         (rsp_valid && rsp_last && state_ff == ST_IDLE))
      else $error("final digit not flagged as last");

endmodule
